@@ design/ia32_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ia32_pkg
// Shared widths, beat layouts and operation codes for the 32-bit integer ALU.
// ----------------------------------------------------------------------------
package ia32_pkg;

  localparam int unsigned DATA_WIDTH  = 32;
  localparam int unsigned OP_WIDTH    = 5;
  localparam int unsigned SHAMT_WIDTH = $clog2(DATA_WIDTH);

  // Request beat: req_type, operand_a, operand_b, padded to whole bytes.
  localparam int unsigned REQ_BITS    = OP_WIDTH + 2 * DATA_WIDTH;
  localparam int unsigned REQ_TDATA_W = ((REQ_BITS + 7) / 8) * 8;

  // Response beat: result_value, compare_flag, padded to whole bytes.
  localparam int unsigned RSP_BITS    = DATA_WIDTH + 1;
  localparam int unsigned RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8;

  // Mask for the "keep the low five bits" operation.
  localparam logic [DATA_WIDTH-1:0] LOW5_MASK = DATA_WIDTH'(5'h1f);

  typedef logic [DATA_WIDTH-1:0] word_t;

  typedef enum logic [OP_WIDTH-1:0] {
    OP_NOR   = 5'd0,
    OP_NOT   = 5'd1,
    OP_NEG   = 5'd2,
    OP_OR    = 5'd3,
    OP_AND   = 5'd4,
    OP_NAND  = 5'd5,
    OP_XOR   = 5'd6,
    OP_XNOR  = 5'd7,
    OP_ADD   = 5'd8,
    OP_SLL   = 5'd9,
    OP_SRL   = 5'd10,
    OP_SRA   = 5'd11,
    OP_EQ    = 5'd12,
    OP_LTU   = 5'd13,
    OP_LT    = 5'd14,
    OP_GEU   = 5'd15,
    OP_GE    = 5'd16,
    OP_LOW5  = 5'd17
  } alu_op_t;

endpackage
`default_nettype wire

@@ design/integer_alu_32.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// integer_alu_32
// Pipelined 32-bit integer ALU: logic, negate, add, shifts and compares.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload (low bit first)
//  s_axis    in         req_type[4:0], operand_a[31:0], operand_b[31:0], pad
//  m_axis    out        result_value[31:0], compare_flag, pad
//
// One beat is accepted every cycle while s_axis_tready is high. The edge that
// accepts a request loads the input register; the result register loads from it
// when the result stage is empty or drains, and m_axis then presents the result.
// Each stage advances whenever the stage after it is empty or drains. A stalled
// output holds the result register; s_axis_tready drops once the input
// register is also full.
// rst is synchronous and empties both stages; payload registers are not reset.
//
module integer_alu_32 import ia32_pkg::*; (
  input  wire                    clk,
  input  wire                    rst,
  // req_type [4:0], operand_a [36:5], operand_b [68:37], zero pad above
  input  wire [REQ_TDATA_W-1:0]  s_axis_tdata,
  input  wire                    s_axis_tvalid,
  output logic                   s_axis_tready,
  // result_value [31:0], compare_flag [32], zero pad above
  output logic [RSP_TDATA_W-1:0] m_axis_tdata,
  output logic                   m_axis_tvalid,
  input  wire                    m_axis_tready
);

  // Input stage.
  logic                in_valid;
  logic [OP_WIDTH-1:0] in_op;
  word_t               in_a;
  word_t               in_b;

  // Result stage.
  logic  out_valid;
  word_t out_value;
  logic  out_flag;

  logic  out_ready;
  logic  in_ready;

  word_t alu_value;
  logic  alu_flag;

  logic                   shamt_big;
  logic [SHAMT_WIDTH-1:0] shamt;
  logic [SHAMT_WIDTH-1:0] sra_shamt;
  logic                   cmp_eq;
  logic                   cmp_ltu;
  logic                   cmp_lt;
  logic                   is_cmp;
  logic                   cmp_true;

  assign out_ready     = !out_valid || m_axis_tready;
  assign in_ready      = !in_valid || out_ready;
  assign s_axis_tready = in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_ready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && s_axis_tvalid) begin
      in_op <= s_axis_tdata[OP_WIDTH-1:0];
      in_a  <= s_axis_tdata[OP_WIDTH +: DATA_WIDTH];
      in_b  <= s_axis_tdata[OP_WIDTH + DATA_WIDTH +: DATA_WIDTH];
    end
  end

  // Any shift amount at or above the word width is flagged from the high bits.
  assign shamt_big = |in_b[DATA_WIDTH-1:SHAMT_WIDTH];
  assign shamt     = in_b[SHAMT_WIDTH-1:0];
  assign sra_shamt = shamt_big ? SHAMT_WIDTH'(DATA_WIDTH - 1) : shamt;

  assign cmp_eq  = (in_a == in_b);
  assign cmp_ltu = (in_a < in_b);
  assign cmp_lt  = ($signed(in_a) < $signed(in_b));

  always_comb begin
    alu_value = '0;
    is_cmp    = 1'b0;
    cmp_true  = 1'b0;
    unique case (alu_op_t'(in_op))
      OP_NOR:  alu_value = ~(in_a | in_b);
      OP_NOT:  alu_value = ~in_a;
      OP_NEG:  alu_value = ~in_a + word_t'(1);
      OP_OR:   alu_value = in_a | in_b;
      OP_AND:  alu_value = in_a & in_b;
      OP_NAND: alu_value = ~(in_a & in_b);
      OP_XOR:  alu_value = in_a ^ in_b;
      OP_XNOR: alu_value = ~(in_a ^ in_b);
      OP_ADD:  alu_value = in_a + in_b;
      OP_SLL:  alu_value = shamt_big ? '0 : (in_a << shamt);
      OP_SRL:  alu_value = shamt_big ? '0 : (in_a >> shamt);
      OP_SRA:  alu_value = word_t'($signed(in_a) >>> sra_shamt);
      OP_EQ: begin
        is_cmp   = 1'b1;
        cmp_true = cmp_eq;
      end
      OP_LTU: begin
        is_cmp   = 1'b1;
        cmp_true = cmp_ltu;
      end
      OP_LT: begin
        is_cmp   = 1'b1;
        cmp_true = cmp_lt;
      end
      OP_GEU: begin
        is_cmp   = 1'b1;
        cmp_true = !cmp_ltu;
      end
      OP_GE: begin
        is_cmp   = 1'b1;
        cmp_true = !cmp_lt;
      end
      OP_LOW5: alu_value = in_a & LOW5_MASK;
      default: alu_value = '0;
    endcase
    if (is_cmp) begin
      alu_value = word_t'(cmp_true);
    end
    alu_flag = is_cmp && cmp_true;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && in_valid) begin
      out_value <= alu_value;
      out_flag  <= alu_flag;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = RSP_TDATA_W'({out_flag, out_value});

endmodule
`default_nettype wire
